[rtl/ws2812_pkg.sv]
package ws2812_pkg;

  // input transaction codes
  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_START  = 2'd1,
    MODE_REFILL = 2'd2
  } mode_e;

  // configuration register indexes
  localparam logic [1:0] CFG_HIGH_DUTY = 2'd0;
  localparam logic [1:0] CFG_LOW_DUTY  = 2'd1;
  localparam logic [1:0] CFG_LED_COUNT = 2'd2;

  localparam logic [15:0] HIGH_DUTY_RST = 16'd51;
  localparam logic [15:0] LOW_DUTY_RST  = 16'd26;
  localparam logic [8:0]  LED_COUNT_RST = 9'd256;

  localparam int unsigned SLOTS = 24;
  localparam int unsigned SLOT_W = 5;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] led_number;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_t;

  typedef struct packed {
    logic [15:0] duty;
    logic        gap_slot;
    logic        last;
  } out_t;

  // refill request from the control logic to the serializer
  typedef struct packed {
    logic valid;
    logic gap;
  } ser_req_t;

endpackage

[rtl/ws2812_ram.sv]
module ws2812_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ws2812_ser.sv]
module ws2812_ser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ws2812_pkg::ser_req_t req_i,
  input  logic [23:0]          rdata_i,
  input  logic [15:0]          high_duty_i,
  input  logic [15:0]          low_duty_i,
  output logic                 pend_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ws2812_pkg::out_t     out_data_o
);

  logic                          pend_q, pend_d;
  logic                          pgap_q, pgap_d;
  logic                          busy_q, busy_d;
  logic                          gap_q, gap_d;
  logic [ws2812_pkg::SLOT_W-1:0] cnt_q, cnt_d;
  logic [23:0]                   sh_q, sh_d;
  logic                          last;
  logic                          pop;
  logic                          load;

  assign last = (cnt_q == ws2812_pkg::SLOT_W'(ws2812_pkg::SLOTS - 1));
  assign pop  = busy_q && out_ready_i;
  assign load = pend_q && (!busy_q || (pop && last));

  always_comb begin
    pend_d = pend_q;
    pgap_d = pgap_q;
    busy_d = busy_q;
    gap_d  = gap_q;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    if (pop) begin
      sh_d  = {sh_q[22:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      pend_d = 1'b0;
      busy_d = 1'b1;
      gap_d  = pgap_q;
      cnt_d  = '0;
      // green, red, blue order on the wire
      sh_d   = pgap_q ? 24'd0 : {rdata_i[15:8], rdata_i[23:16], rdata_i[7:0]};
    end
    if (req_i.valid) begin
      pend_d = 1'b1;
      pgap_d = req_i.gap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      pend_q <= pend_d;
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pgap_q <= pgap_d;
    gap_q  <= gap_d;
    sh_q   <= sh_d;
  end

  assign pend_o              = pend_q;
  assign out_valid_o         = busy_q;
  assign out_data_o.duty     = gap_q ? 16'd0 : (sh_q[23] ? high_duty_i : low_duty_i);
  assign out_data_o.gap_slot = gap_q;
  assign out_data_o.last     = last;

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= ws2812_pkg::SLOT_W'(ws2812_pkg::SLOTS - 1))
    else $error("slot counter out of range");

  a_load_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !busy_q) |=> busy_q)
    else $error("pending refill not loaded");

  a_run_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && last && pend_q) |=> (busy_q && cnt_q == '0))
    else $error("queued refill did not follow the finished run");

endmodule

[rtl/ws2812_grb_pwm_encoder.sv]
// a refill queues a request in the serializer while the store read is registered; the
// serializer loads it when idle or as the last slot of a run is taken, so runs go back to
// back; a run is 24 slots at one compare value per cycle while out_ready_i is high
// reset: asynchronous active low, then a clearing pass zeroes every color store entry
// while in_ready_o stays low; config writes are taken during the pass
module ws2812_grb_pwm_encoder #(
  parameter int unsigned MAX_LEDS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ws2812_pkg::in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ws2812_pkg::out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_wdata_i
);

  // address width of the color store, width of the led counter, width of compares
  localparam int unsigned AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int unsigned CW = $clog2(MAX_LEDS + 1);
  localparam int unsigned EW = (CW > 9) ? CW : 9;

  // configuration registers
  logic [15:0] hd_q;
  logic [15:0] ld_q;
  logic [8:0]  cnt_q;

  // frame state
  logic [CW-1:0] nl_q, nl_d;
  logic          gap_q, gap_d;

  // clearing pass after reset
  logic          clr_q, clr_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  logic          acc;
  logic          pend;
  logic [EW-1:0] eff;
  logic [EW-1:0] cnt_ext;
  logic [EW-1:0] led_ext;
  logic [CW-1:0] nl_inc;
  logic          wr_ok;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [23:0]   ram_wdata;
  logic          ram_re;
  logic [23:0]   ram_rdata;
  ws2812_pkg::ser_req_t req;

  // a refill waits while one is already queued for the serializer
  assign in_ready_o = !clr_q &&
                      ((in_data_i.mode != ws2812_pkg::MODE_REFILL) || !pend);
  assign acc        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hd_q  <= ws2812_pkg::HIGH_DUTY_RST;
      ld_q  <= ws2812_pkg::LOW_DUTY_RST;
      cnt_q <= ws2812_pkg::LED_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ws2812_pkg::CFG_HIGH_DUTY: hd_q  <= cfg_wdata_i;
        ws2812_pkg::CFG_LOW_DUTY:  ld_q  <= cfg_wdata_i;
        ws2812_pkg::CFG_LED_COUNT: cnt_q <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // effective led count, saturated to 1..MAX_LEDS
  assign cnt_ext = EW'(cnt_q);
  always_comb begin
    if (cnt_q == 9'd0) begin
      eff = EW'(1);
    end else if (cnt_ext > EW'(MAX_LEDS)) begin
      eff = EW'(MAX_LEDS);
    end else begin
      eff = cnt_ext;
    end
  end

  assign led_ext = EW'(in_data_i.led_number);
  assign nl_inc  = nl_q + 1'b1;

  // per transaction decode: in-range writes hit the store, start and refill move the frame
  always_comb begin
    wr_ok  = 1'b0;
    ram_re = 1'b0;
    nl_d   = nl_q;
    gap_d  = gap_q;
    req    = '0;
    if (acc) begin
      case (in_data_i.mode)
        ws2812_pkg::MODE_WRITE: begin
          wr_ok = (led_ext < eff);
        end
        ws2812_pkg::MODE_START: begin
          // ignored while a frame runs
          if (gap_q) begin
            nl_d  = '0;
            gap_d = 1'b0;
          end
        end
        ws2812_pkg::MODE_REFILL: begin
          req.valid = 1'b1;
          req.gap   = gap_q;
          if (!gap_q) begin
            ram_re = 1'b1;
            nl_d   = nl_inc;
            // frame ends once the next led is at or past the count in force now
            gap_d  = (EW'(nl_inc) >= eff);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(MAX_LEDS - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nl_q      <= '0;
      gap_q     <= 1'b1;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      nl_q      <= nl_d;
      gap_q     <= gap_d;
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // store port: zeroes during the clearing pass, color writes afterwards
  assign ram_we    = clr_q || wr_ok;
  assign ram_waddr = clr_q ? clr_cnt_q : led_ext[AW-1:0];
  assign ram_wdata = clr_q ? 24'd0
                           : {in_data_i.red, in_data_i.green, in_data_i.blue};

  ws2812_ram #(
    .WIDTH(24),
    .DEPTH(MAX_LEDS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(nl_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // slot serializer with one queued refill and the output register
  ws2812_ser u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rdata_i    (ram_rdata),
    .high_duty_i(hd_q),
    .low_duty_i (ld_q),
    .pend_o     (pend),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  a_no_out_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !out_valid_o)
    else $error("output transaction during clearing pass");

  a_frame_led_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !gap_q |-> (EW'(nl_q) < EW'(MAX_LEDS)))
    else $error("frame running past the store depth");

  a_refill_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid |=> pend)
    else $error("accepted refill not queued");

  a_start_opens : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_data_i.mode == ws2812_pkg::MODE_START && gap_q) |=> (!gap_q && nl_q == '0))
    else $error("start did not open a frame");

endmodule
